/* rtl/core/spd_pkg.sv */
package spd_pkg;

  // Width of the timestamp arithmetic; the timestamp field itself is 32 bits.
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  // Configuration register indexes.
  localparam logic REG_BEGIN_TIMEOUT = 1'b0;
  localparam logic REG_END_TIMEOUT   = 1'b1;

  // Output queue depth and pointer widths.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    EV_BEGIN  = 2'd0,
    EV_UPDATE = 2'd1,
    EV_END    = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [3:0] rec;
    logic [3:0] tab;
    logic       last;
  } event_t;

  // Results of one item: how many events and the events themselves.
  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } step_out_t;

endpackage

/* rtl/core/spd_step.sv */
module spd_step
  import spd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        accept_i,
  input  logic        req_type_i,
  input  logic [31:0] timestamp_ms_i,
  input  logic        scene_present_i,
  input  logic        record_valid_i,
  input  logic [3:0]  record_kind_i,
  input  logic        tab_valid_i,
  input  logic [3:0]  tab_index_i,
  output step_out_t   step_o
);

  logic [31:0]   begin_timeout_q, end_timeout_q;
  logic          active_q, active_d;
  logic          bw_valid_q, bw_valid_d;
  logic [TW-1:0] bw_since_q, bw_since_d;
  logic [3:0]    bw_kind_q, bw_kind_d;
  logic          ew_valid_q, ew_valid_d;
  logic [TW-1:0] ew_since_q, ew_since_d;

  logic [TW-1:0] now;
  logic [TW-1:0] bw_elapsed, ew_elapsed;
  logic          present;

  assign now     = timestamp_ms_i[TW-1:0];
  assign present = scene_present_i & record_valid_i & tab_valid_i;

  // Elapsed times saturate at zero when the timestamp went backwards.
  assign bw_elapsed = (now >= bw_since_q) ? now - bw_since_q : '0;
  assign ew_elapsed = (now >= ew_since_q) ? now - ew_since_q : '0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_timeout_q <= '0;
      end_timeout_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BEGIN_TIMEOUT) begin
        begin_timeout_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_END_TIMEOUT) begin
        end_timeout_q <= cfg_data_i;
      end
    end
  end

  // Debounce step for one item: next state and up to two events.
  always_comb begin
    logic   go;
    logic   end_now;
    event_t ev;
    active_d   = active_q;
    bw_valid_d = bw_valid_q;
    bw_since_d = bw_since_q;
    bw_kind_d  = bw_kind_q;
    ew_valid_d = ew_valid_q;
    ew_since_d = ew_since_q;
    step_o     = '0;
    go         = 1'b0;
    end_now    = 1'b0;
    ev         = '0;

    if (req_type_i) begin
      // Idle event: close any scene and drop the begin wait.
      end_now    = active_q;
      bw_valid_d = 1'b0;
      bw_since_d = '0;
      bw_kind_d  = '0;
    end else if (present) begin
      ew_valid_d = 1'b0;
      ew_since_d = '0;
      if (!active_q) begin
        if (begin_timeout_q == '0) begin
          go = 1'b1;
        end else if (!bw_valid_q || bw_kind_q != record_kind_i) begin
          bw_valid_d = 1'b1;
          bw_since_d = now;
          bw_kind_d  = record_kind_i;
        end else if (32'(bw_elapsed) >= begin_timeout_q) begin
          go = 1'b1;
        end
        if (go) begin
          active_d   = 1'b1;
          bw_valid_d = 1'b0;
          bw_since_d = '0;
          bw_kind_d  = '0;
        end
      end
      // Begin then update, or update alone.
      if (go) begin
        ev.kind      = EV_BEGIN;
        ev.rec       = record_kind_i;
        step_o.ev0   = ev;
        ev.kind      = EV_UPDATE;
        ev.tab       = tab_index_i;
        ev.last      = 1'b1;
        step_o.ev1   = ev;
        step_o.count = 2'd2;
      end else if (active_q) begin
        ev.kind      = EV_UPDATE;
        ev.rec       = record_kind_i;
        ev.tab       = tab_index_i;
        ev.last      = 1'b1;
        step_o.ev0   = ev;
        step_o.count = 2'd1;
      end
    end else begin
      // Absent frame: drop the begin wait and run the end timer.
      bw_valid_d = 1'b0;
      bw_since_d = '0;
      bw_kind_d  = '0;
      if (active_q) begin
        if (end_timeout_q == '0) begin
          end_now = 1'b1;
        end else if (!ew_valid_q) begin
          ew_valid_d = 1'b1;
          ew_since_d = now;
        end else if (32'(ew_elapsed) >= end_timeout_q) begin
          end_now = 1'b1;
        end
      end
    end

    if (end_now) begin
      active_d     = 1'b0;
      ew_valid_d   = 1'b0;
      ew_since_d   = '0;
      ev           = '0;
      ev.kind      = EV_END;
      ev.last      = 1'b1;
      step_o.ev0   = ev;
      step_o.count = 2'd1;
    end
  end

  // Scene state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      bw_valid_q <= 1'b0;
      bw_since_q <= '0;
      bw_kind_q  <= '0;
      ew_valid_q <= 1'b0;
      ew_since_q <= '0;
    end else if (accept_i) begin
      active_q   <= active_d;
      bw_valid_q <= bw_valid_d;
      bw_since_q <= bw_since_d;
      bw_kind_q  <= bw_kind_d;
      ew_valid_q <= ew_valid_d;
      ew_since_q <= ew_since_d;
    end
  end

endmodule

/* rtl/core/spd_out_queue.sv */
module spd_out_queue
  import spd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  step_out_t step_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output event_t    out_o
);

  event_t            entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n      = push_i ? step_i.count : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign out_o       = entry_q[rd_q];
  // Room for the largest burst one item can cause.
  assign space_o     = (cnt_q <= QCNT_W'(QDEPTH - 2));

  // Event storage; an item writes one or two consecutive entries.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      entry_q[wr_q] <= step_i.ev0;
    end
    if (push_n == 2'd2) begin
      entry_q[wr_q + QPTR_W'(1)] <= step_i.ev1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_n);
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

endmodule

/* rtl/core/scene_presence_debouncer_top.sv */
// Scene presence debouncer. Each input item is a timestamped frame verdict or
// an idle event; it yields zero, one or two result items (scene begin, update,
// end), the final one of an item flagged by last_o. An item is taken every
// cycle while the four-entry output queue has room for two results, so the
// block runs at one item per cycle as long as results are drained at least as
// fast as they are produced; the queue drain of one result per cycle sets the
// limit when items produce two results. Timeouts must be written over the cfg
// port only while idle (not enforced); a zero timeout acts on the same frame.
module scene_presence_debouncer_top
  import spd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] timestamp_ms_i,
  input  logic        scene_present_i,
  input  logic        record_valid_i,
  input  logic [3:0]  record_kind_i,
  input  logic        tab_valid_i,
  input  logic [3:0]  tab_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  event_record_o,
  output logic [3:0]  event_tab_o,
  output logic        last_o
);

  step_out_t step;
  event_t    head;
  logic      accept;

  assign accept = in_valid_i & in_ready_o;

  // Scene state and per-item decision.
  spd_step u_step (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .accept_i (accept),
    .req_type_i,
    .timestamp_ms_i,
    .scene_present_i,
    .record_valid_i,
    .record_kind_i,
    .tab_valid_i,
    .tab_index_i,
    .step_o   (step)
  );

  // Result queue between the decision and the output channel.
  spd_out_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (accept),
    .step_i      (step),
    .space_o     (in_ready_o),
    .out_valid_o,
    .out_ready_i,
    .out_o       (head)
  );

  assign event_kind_o   = head.kind;
  assign event_record_o = head.rec;
  assign event_tab_o    = head.tab;
  assign last_o         = head.last;

endmodule
